/* rtl/prtp_pkg.sv */
package prtp_pkg;

    // configuration register indexes
    localparam logic [2:0] CFG_ANGLE_X = 3'd0;
    localparam logic [2:0] CFG_ANGLE_Y = 3'd1;
    localparam logic [2:0] CFG_ANGLE_Z = 3'd2;
    localparam logic [2:0] CFG_SHIFT_X = 3'd3;
    localparam logic [2:0] CFG_SHIFT_Y = 3'd4;
    localparam logic [2:0] CFG_SHIFT_Z = 3'd5;

    // default parameter values
    localparam int ANGLE_BITS_DEF     = 10;
    localparam int FOCAL_DISTANCE_DEF = 200;
    localparam int SCREEN_WIDTH_DEF   = 320;
    localparam int SCREEN_HEIGHT_DEF  = 200;

    // field widths
    localparam int PT_W   = 20;
    localparam int CFG_W  = 20;
    localparam int TRIG_W = 16;
    localparam int SCR_W  = 12;

    // translated coordinate width and projection numerator width
    localparam int XF_W  = 27;
    localparam int NUM_W = 40;

    // quotient magnitude bits, two per divider stage
    localparam int QUO_W  = 12;
    localparam int DIV_ST = QUO_W / 2;

    localparam logic [15:0] SHIFT_Z_RST = 16'd51200;

    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

    // sideband that travels beside the divider stages
    typedef struct packed {
        logic vld;
        logic front;
        logic neg_x;
        logic neg_y;
    } t_side;

    // quarter-wave sine in q1.15, evaluated at elaboration only
    function automatic logic signed [15:0] quarter_sine(input int unsigned k,
                                                        input int unsigned qb);
        longint unsigned x;
        longint unsigned mag;
        longint          sum;
        longint          rnd;
        int              n;
        x   = (longint'(k) * HALF_PI_Q30) >> qb;
        mag = x;
        sum = longint'(x);
        for (n = 1; n <= 9; n++) begin
            mag = (mag * x) >> 30;
            mag = (mag * x) >> 30;
            unique case (n)
                1: mag = mag / 6;
                2: mag = mag / 20;
                3: mag = mag / 42;
                4: mag = mag / 72;
                5: mag = mag / 110;
                6: mag = mag / 156;
                7: mag = mag / 210;
                8: mag = mag / 272;
                default: mag = mag / 342;
            endcase
            if (n % 2 == 1) sum = sum - longint'(mag);
            else sum = sum + longint'(mag);
        end
        if (sum < 0) sum = 0;
        if (sum > (64'sd1 <<< 30)) sum = 64'sd1 <<< 30;
        rnd = (sum * 32767 + (64'sd1 <<< 29)) >>> 30;
        return rnd[15:0];
    endfunction

endpackage

/* rtl/prtp_div.sv */
module prtp_div import prtp_pkg::*; #(
    parameter int DEN_W = XF_W
) (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic [NUM_W-1:0]     i_num,
    input  logic [DEN_W-1:0]     i_den,
    output logic [QUO_W-1:0]     o_quo,
    output logic                 o_ovf
);

    logic [NUM_W-1:0] r_rem [DIV_ST];
    logic [DEN_W-1:0] r_den [DIV_ST];
    logic [QUO_W-1:0] r_quo [DIV_ST];
    logic             r_ovf [DIV_ST];

    for (genvar s = 0; s < DIV_ST; s++) begin : g_st
        localparam int B1 = QUO_W - 1 - 2 * s;
        localparam int B0 = B1 - 1;

        logic [NUM_W-1:0] w_rem_in;
        logic [DEN_W-1:0] w_den_in;
        logic [QUO_W-1:0] w_quo_in;
        logic             w_ovf_in;
        logic [NUM_W-1:0] w_t1;
        logic [NUM_W-1:0] w_t0;
        logic [NUM_W-1:0] w_rem_mid;
        logic [NUM_W-1:0] n_rem;
        logic [QUO_W-1:0] n_quo;

        // stage input, first stage also checks for quotient overflow
        if (s == 0) begin : g_first
            assign w_rem_in = i_num;
            assign w_den_in = i_den;
            assign w_quo_in = '0;
            assign w_ovf_in = (i_num >= (NUM_W'(i_den) << QUO_W));
        end else begin : g_next
            assign w_rem_in = r_rem[s-1];
            assign w_den_in = r_den[s-1];
            assign w_quo_in = r_quo[s-1];
            assign w_ovf_in = r_ovf[s-1];
        end

        // two restoring steps
        always_comb begin
            w_t1      = NUM_W'(w_den_in) << B1;
            w_t0      = NUM_W'(w_den_in) << B0;
            n_quo     = w_quo_in;
            w_rem_mid = w_rem_in;
            if (w_rem_in >= w_t1) begin
                w_rem_mid = w_rem_in - w_t1;
                n_quo[B1] = 1'b1;
            end
            n_rem = w_rem_mid;
            if (w_rem_mid >= w_t0) begin
                n_rem     = w_rem_mid - w_t0;
                n_quo[B0] = 1'b1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s] <= n_rem;
                r_den[s] <= w_den_in;
                r_quo[s] <= n_quo;
                r_ovf[s] <= w_ovf_in;
            end
        end
    end

    assign o_quo = r_quo[DIV_ST-1];
    assign o_ovf = r_ovf[DIV_ST-1];

endmodule

/* rtl/point_rotate_translate_project.sv */
// throughput: one point per cycle; the pipeline holds all stages while the output is stalled
// stages: three rotations, translate, projection products, magnitudes, six divider stages, output
// reset: synchronous active low, clears valids, angles to zero and translation to 0, 0, -200.0
module point_rotate_translate_project import prtp_pkg::*; #(
    parameter int ANGLE_BITS     = ANGLE_BITS_DEF,
    parameter int FOCAL_DISTANCE = FOCAL_DISTANCE_DEF,
    parameter int SCREEN_WIDTH   = SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT  = SCREEN_HEIGHT_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_stall,
    input  logic signed [PT_W-1:0]  i_point_x,
    input  logic signed [PT_W-1:0]  i_point_y,
    input  logic signed [PT_W-1:0]  i_point_z,
    output logic                    o_valid,
    input  logic                    i_stall,
    output logic signed [SCR_W-1:0] o_screen_x,
    output logic signed [SCR_W-1:0] o_screen_y,
    output logic                    o_in_front,
    input  logic                    i_cfg_we,
    input  logic [2:0]              i_cfg_idx,
    input  logic [CFG_W-1:0]        i_cfg_data
);

    localparam int QUARTER = 1 << (ANGLE_BITS - 2);
    localparam int QI_W    = ANGLE_BITS - 1;

    localparam logic signed [NUM_W-1:0] F_K  = NUM_W'(FOCAL_DISTANCE);
    localparam logic signed [NUM_W-1:0] CX_K = NUM_W'(SCREEN_WIDTH / 2);
    localparam logic signed [NUM_W-1:0] CY_K = NUM_W'(SCREEN_HEIGHT / 2);

    // quarter-wave sine table, constant
    logic signed [TRIG_W-1:0] w_qtab [QUARTER+1];

    for (genvar k = 0; k <= QUARTER; k++) begin : g_qtab
        localparam logic signed [TRIG_W-1:0] QV = quarter_sine(k, ANGLE_BITS - 2);
        assign w_qtab[k] = QV;
    end

    // sine and cosine lookup of the angle being written
    logic [ANGLE_BITS-1:0]    w_ang_idx [2];
    logic signed [TRIG_W-1:0] w_trig    [2];

    always_comb begin
        logic [1:0]            quad;
        logic [ANGLE_BITS-3:0] kk;
        logic [QI_W-1:0]       qi;
        logic signed [TRIG_W-1:0] v;
        w_ang_idx[0] = i_cfg_data[15 -: ANGLE_BITS];
        w_ang_idx[1] = i_cfg_data[15 -: ANGLE_BITS] + ANGLE_BITS'(QUARTER);
        for (int j = 0; j < 2; j++) begin
            quad = w_ang_idx[j][ANGLE_BITS-1 -: 2];
            kk   = w_ang_idx[j][ANGLE_BITS-3:0];
            qi   = quad[0] ? (QI_W'(QUARTER) - {1'b0, kk}) : {1'b0, kk};
            v    = w_qtab[qi];
            w_trig[j] = quad[1] ? -v : v;
        end
    end

    // configuration: sine and cosine per axis, translation per axis
    logic signed [TRIG_W-1:0] r_sin   [3];
    logic signed [TRIG_W-1:0] r_cos   [3];
    logic signed [PT_W-1:0]   r_shift [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < 3; j++) begin
                r_sin[j] <= '0;
                r_cos[j] <= w_qtab[QUARTER];
            end
            r_shift[0] <= '0;
            r_shift[1] <= '0;
            r_shift[2] <= -$signed({4'd0, SHIFT_Z_RST});
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_ANGLE_X: begin
                    r_sin[0] <= w_trig[0];
                    r_cos[0] <= w_trig[1];
                end
                CFG_ANGLE_Y: begin
                    r_sin[1] <= w_trig[0];
                    r_cos[1] <= w_trig[1];
                end
                CFG_ANGLE_Z: begin
                    r_sin[2] <= w_trig[0];
                    r_cos[2] <= w_trig[1];
                end
                CFG_SHIFT_X: r_shift[0] <= i_cfg_data;
                CFG_SHIFT_Y: r_shift[1] <= i_cfg_data;
                CFG_SHIFT_Z: r_shift[2] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // pipeline advance: move unless a result waits on a stalled output
    logic r_out_v;
    logic w_adv;

    assign w_adv   = !r_out_v || !i_stall;
    assign o_stall = !w_adv;

    logic r_v [5];

    // stage 1: rotate about x
    logic signed [36:0] w1_a, w1_b;
    logic signed [19:0] r1_x;
    logic signed [21:0] r1_y, r1_z;

    assign w1_a = i_point_y * r_cos[0] - i_point_z * r_sin[0] + 37'sd16384;
    assign w1_b = i_point_y * r_sin[0] + i_point_z * r_cos[0] + 37'sd16384;

    // stage 2: rotate about y
    logic signed [38:0] w2_a, w2_b;
    logic signed [23:0] r2_x, r2_z;
    logic signed [21:0] r2_y;

    assign w2_a = r1_x * r_cos[1] - r1_z * r_sin[1] + 39'sd16384;
    assign w2_b = r1_x * r_sin[1] + r1_z * r_cos[1] + 39'sd16384;

    // stage 3: rotate about z
    logic signed [40:0] w3_a, w3_b;
    logic signed [25:0] r3_x, r3_y;
    logic signed [23:0] r3_z;

    assign w3_a = r2_x * r_cos[2] - r2_y * r_sin[2] + 41'sd16384;
    assign w3_b = r2_x * r_sin[2] + r2_y * r_cos[2] + 41'sd16384;

    // stage 4: translate
    logic signed [XF_W-1:0] r4_x, r4_y, r4_z;

    // stage 5: projection numerators
    logic signed [NUM_W-1:0] r5_nx, r5_ny;
    logic signed [XF_W-1:0]  r5_z;

    // stage 6: magnitudes and quotient signs
    logic [NUM_W-1:0] r6_nxm, r6_nym;
    logic [XF_W-1:0]  r6_zm;
    t_side            r6_side;
    t_side            n6_side;

    always_comb begin
        n6_side.vld   = r_v[4];
        n6_side.front = r5_z[XF_W-1];
        n6_side.neg_x = r5_nx[NUM_W-1] ^ r5_z[XF_W-1];
        n6_side.neg_y = r5_ny[NUM_W-1] ^ r5_z[XF_W-1];
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r1_x   <= i_point_x;
            r1_y   <= w1_a[36:15];
            r1_z   <= w1_b[36:15];
            r2_x   <= w2_a[38:15];
            r2_y   <= r1_y;
            r2_z   <= w2_b[38:15];
            r3_x   <= w3_a[40:15];
            r3_y   <= w3_b[40:15];
            r3_z   <= r2_z;
            r4_x   <= XF_W'(r3_x) + XF_W'(r_shift[0]);
            r4_y   <= XF_W'(r3_y) + XF_W'(r_shift[1]);
            r4_z   <= XF_W'(r3_z) + XF_W'(r_shift[2]);
            r5_nx  <= r4_x * F_K + CX_K * r4_z;
            r5_ny  <= r4_y * F_K + CY_K * r4_z;
            r5_z   <= r4_z;
            r6_nxm <= r5_nx[NUM_W-1] ? NUM_W'(-r5_nx) : NUM_W'(r5_nx);
            r6_nym <= r5_ny[NUM_W-1] ? NUM_W'(-r5_ny) : NUM_W'(r5_ny);
            r6_zm  <= r5_z[XF_W-1] ? XF_W'(-r5_z) : XF_W'(r5_z);
        end
    end

    // valid bits of the front stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < 5; j++) r_v[j] <= 1'b0;
            r6_side <= '0;
        end else if (w_adv) begin
            r_v[0] <= i_valid;
            for (int j = 1; j < 5; j++) r_v[j] <= r_v[j-1];
            r6_side <= n6_side;
        end
    end

    // dividers for both screen axes
    logic [QUO_W-1:0] w_qx, w_qy;
    logic             w_ovx, w_ovy;

    prtp_div #(.DEN_W(XF_W)) u_div_x (
        .i_clk (i_clk),
        .i_en  (w_adv),
        .i_num (r6_nxm),
        .i_den (r6_zm),
        .o_quo (w_qx),
        .o_ovf (w_ovx)
    );

    prtp_div #(.DEN_W(XF_W)) u_div_y (
        .i_clk (i_clk),
        .i_en  (w_adv),
        .i_num (r6_nym),
        .i_den (r6_zm),
        .o_quo (w_qy),
        .o_ovf (w_ovy)
    );

    // sideband beside the divider stages
    t_side r_dside [DIV_ST];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < DIV_ST; j++) r_dside[j] <= '0;
        end else if (w_adv) begin
            r_dside[0] <= r6_side;
            for (int j = 1; j < DIV_ST; j++) r_dside[j] <= r_dside[j-1];
        end
    end

    // sign and saturation of a quotient magnitude
    function automatic logic signed [SCR_W-1:0] sat_q(input logic [QUO_W-1:0] q,
                                                      input logic ovf,
                                                      input logic neg);
        logic big;
        big = ovf || q[QUO_W-1];
        if (neg) return big ? {1'b1, {(SCR_W-1){1'b0}}} : SCR_W'(-q);
        return big ? {1'b0, {(SCR_W-1){1'b1}}} : SCR_W'(q);
    endfunction

    t_side                   w_dend;
    logic signed [SCR_W-1:0] n_sx, n_sy;
    logic signed [SCR_W-1:0] r_sx, r_sy;
    logic                    r_front;

    assign w_dend = r_dside[DIV_ST-1];

    always_comb begin
        n_sx = '0;
        n_sy = '0;
        if (w_dend.front) begin
            n_sx = sat_q(w_qx, w_ovx, w_dend.neg_x);
            n_sy = sat_q(w_qy, w_ovy, w_dend.neg_y);
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (w_adv) begin
            r_out_v <= w_dend.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_sx    <= n_sx;
            r_sy    <= n_sy;
            r_front <= w_dend.front;
        end
    end

    assign o_valid    = r_out_v;
    assign o_screen_x = r_sx;
    assign o_screen_y = r_sy;
    assign o_in_front = r_front;

endmodule

/* rtl/prtp_chk.sv */
module prtp_chk import prtp_pkg::*; (
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    i_valid,
    input logic                    o_stall,
    input logic signed [PT_W-1:0]  i_point_x,
    input logic signed [PT_W-1:0]  i_point_y,
    input logic signed [PT_W-1:0]  i_point_z,
    input logic                    o_valid,
    input logic                    i_stall,
    input logic signed [SCR_W-1:0] o_screen_x,
    input logic signed [SCR_W-1:0] o_screen_y,
    input logic                    o_in_front,
    input logic                    i_cfg_we,
    input logic [2:0]              i_cfg_idx,
    input logic [CFG_W-1:0]        i_cfg_data
);

    // no result right after reset
    a_rst_clear: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    // input stalls only behind a held result
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("input stalled without a held result");

    // a point behind the viewer gives zero coordinates
    a_behind_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_in_front) |-> (o_screen_x == 0 && o_screen_y == 0))
        else $error("nonzero screen position for a point behind");

    // a stalled result stays
    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> o_valid)
        else $error("result dropped under stall");

    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> ($stable(o_screen_x) && $stable(o_screen_y)
                                  && $stable(o_in_front)))
        else $error("result changed under stall");

endmodule

bind point_rotate_translate_project prtp_chk u_prtp_chk (.*);
